@@ sv/rdc_pkg.sv @@
// Shared types, codes and the Q1.15 sine table for the rotation direction classifier.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

  // Field widths
  localparam int COORD_WIDTH = 10;
  localparam int COUNT_WIDTH = 24;
  localparam int OUT_WIDTH   = 24;
  localparam int DEG_WIDTH   = 9;
  localparam int SINE_WIDTH  = 16;
  localparam int VEC_WIDTH   = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = SINE_WIDTH + VEC_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 1;
  localparam int ROM_IDX_W   = 7;

  // Configuration register indexes and reset values
  localparam logic [1:0] REG_ORIGIN_X     = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y     = 2'd1;
  localparam logic [1:0] REG_COORD_SOURCE = 2'd2;

  localparam logic [COORD_WIDTH-1:0] ORIGIN_X_RESET = COORD_WIDTH'(512);
  localparam logic [COORD_WIDTH-1:0] ORIGIN_Y_RESET = COORD_WIDTH'(512);

  // Coordinate source codes
  localparam logic [1:0] SRC_ROOM  = 2'd0;
  localparam logic [1:0] SRC_ARENA = 2'd1;
  localparam logic [1:0] SRC_RED   = 2'd2;

  // Result categories
  localparam logic [1:0] CAT_SKIP = 2'd0;
  localparam logic [1:0] CAT_CCW  = 2'd1;
  localparam logic [1:0] CAT_CW   = 2'd2;

  // Angle constants in degrees
  localparam logic [DEG_WIDTH-1:0] DEG_90  = DEG_WIDTH'(90);
  localparam logic [DEG_WIDTH-1:0] DEG_180 = DEG_WIDTH'(180);
  localparam logic [DEG_WIDTH-1:0] DEG_270 = DEG_WIDTH'(270);
  localparam logic [DEG_WIDTH-1:0] DEG_360 = DEG_WIDTH'(360);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // sin(k) for k = 0..90 degrees, Q1.15
  localparam logic [SINE_WIDTH-1:0] SINE_ROM [0:90] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32523,
    16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32767
  };

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [COORD_WIDTH-1:0] origin_x;
    logic [COORD_WIDTH-1:0] origin_y;
    logic [1:0]             coord_source;
  } rdc_cfg_t;

  // One input item as it arrives
  typedef struct packed {
    logic [COORD_WIDTH-1:0] room_x;
    logic [COORD_WIDTH-1:0] room_y;
    logic [COORD_WIDTH-1:0] arena_x;
    logic [COORD_WIDTH-1:0] arena_y;
    logic [COORD_WIDTH-1:0] red_x;
    logic [COORD_WIDTH-1:0] red_y;
    logic [DEG_WIDTH-1:0]   heading;
    logic                   heading_valid;
    logic                   final_record;
  } rdc_raw_t;

  // Position vector and heading sine/cosine
  typedef struct packed {
    logic signed [VEC_WIDTH-1:0]  x;
    logic signed [VEC_WIDTH-1:0]  y;
    logic signed [SINE_WIDTH-1:0] s;
    logic signed [SINE_WIDTH-1:0] c;
    logic                         live;
    logic                         last;
  } rdc_vec_t;

  // The four partial products of the cross and dot products
  typedef struct packed {
    logic signed [PROD_WIDTH-1:0] sx;
    logic signed [PROD_WIDTH-1:0] cy;
    logic signed [PROD_WIDTH-1:0] cx;
    logic signed [PROD_WIDTH-1:0] sy;
    logic                         live;
    logic                         last;
  } rdc_prod_t;

  // One result item
  typedef struct packed {
    logic [OUT_WIDTH-1:0] cw_total;
    logic [OUT_WIDTH-1:0] ccw_total;
    logic [OUT_WIDTH-1:0] slot;
    logic [1:0]           category;
    logic                 last;
  } rdc_res_t;

  // Signed Q1.15 sine of a heading in 0..359 degrees, by quadrant symmetry
  function automatic logic signed [SINE_WIDTH-1:0] sine_q15(input logic [DEG_WIDTH-1:0] deg);
    logic [ROM_IDX_W-1:0]  idx;
    logic                  neg;
    logic [SINE_WIDTH-1:0] mag;
    if (deg <= DEG_90) begin
      idx = ROM_IDX_W'(deg);
      neg = 1'b0;
    end else if (deg <= DEG_180) begin
      idx = ROM_IDX_W'(DEG_180 - deg);
      neg = 1'b0;
    end else if (deg <= DEG_270) begin
      idx = ROM_IDX_W'(deg - DEG_180);
      neg = 1'b1;
    end else begin
      idx = ROM_IDX_W'(DEG_360 - deg);
      neg = 1'b1;
    end
    mag = SINE_ROM[idx];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

`default_nettype wire

@@ sv/rotation_direction_classifier.sv @@
// Rotation direction classifier: classifies tracking records as counterclockwise or
// clockwise about a configured center and numbers them per session.
// Input items arrive on the s_axis channel, results leave on m_axis, and the
// center and coordinate source are set through the APB-style port.
// Each result carries a category (skipped, counterclockwise, clockwise), the
// record's slot within its category and the running totals of both categories.
// An accepted item passes in order through the input register, geometry and sine
// lookup, products, and decision and counters before its result is valid.
// Throughput: one item per cycle while the receiver takes results, with the counters
// updated in the decision stage; every stage holds one item.
// Reset clears all stage valids, both counters and the registers to their
// defaults (center 512, 512; camera red spot pair).
// When the receiver stalls, the result register holds and stages behind it keep
// filling; s_axis_tready falls only once every stage holds an item.
// A record with tlast set ends the session: both counters clear after it.
// Depends on rdc_pkg, rdc_cfg, rdc_geom, rdc_mult and rdc_decide.
`timescale 1ns / 1ps
`default_nettype none

module rotation_direction_classifier (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // room_x, room_y, arena_x, arena_y, red_x, red_y (10 bits each), heading (9), pad
  input  wire logic [71:0] s_axis_tdata,
  // heading_valid
  input  wire logic [0:0]  s_axis_tuser,
  // final_record
  input  wire logic        s_axis_tlast,
  // Result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // category (2), slot (24), ccw_total (24), cw_total (24), pad
  output logic [79:0]      m_axis_tdata,
  // final_flag
  output logic             m_axis_tlast,
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  rdc_pkg::rdc_cfg_t  cfg;
  rdc_pkg::rdc_raw_t  raw;
  rdc_pkg::rdc_vec_t  vec;
  rdc_pkg::rdc_prod_t prod;
  rdc_pkg::rdc_res_t  res;
  logic               vec_valid;
  logic               vec_ready;
  logic               prod_valid;
  logic               prod_ready;

  // Unpack the input item
  assign raw.room_x        = s_axis_tdata[9:0];
  assign raw.room_y        = s_axis_tdata[19:10];
  assign raw.arena_x       = s_axis_tdata[29:20];
  assign raw.arena_y       = s_axis_tdata[39:30];
  assign raw.red_x         = s_axis_tdata[49:40];
  assign raw.red_y         = s_axis_tdata[59:50];
  assign raw.heading       = s_axis_tdata[68:60];
  assign raw.heading_valid = s_axis_tuser[0];
  assign raw.final_record  = s_axis_tlast;

  rdc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rdc_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_raw    (raw),
    .out_valid (vec_valid),
    .out_ready (vec_ready),
    .out_vec   (vec)
  );

  rdc_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vec_valid),
    .in_ready  (vec_ready),
    .in_vec    (vec),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_prod  (prod)
  );

  rdc_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_prod   (prod),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  // Pack the result item
  assign m_axis_tdata = {6'd0, res.cw_total, res.ccw_total, res.slot, res.category};
  assign m_axis_tlast = res.last;

  // A skipped record never carries a slot
  a_skip_slot_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.category == rdc_pkg::CAT_SKIP |-> res.slot == '0)
    else $error("skipped result with non-zero slot");

  // A counted record leaves its category total non-zero
  a_ccw_total: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.category == rdc_pkg::CAT_CCW |-> res.ccw_total != '0)
    else $error("counterclockwise result with zero total");

  a_cw_total: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.category == rdc_pkg::CAT_CW |-> res.cw_total != '0)
    else $error("clockwise result with zero total");

  // The input side backs up only behind a waiting result
  a_ready_backup: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

endmodule

`default_nettype wire

@@ sv/rdc_cfg.sv @@
// APB-style configuration registers: center coordinates and coordinate source.
// Depends on rdc_pkg for register indexes, reset values and the rdc_cfg_t type.
`timescale 1ns / 1ps
`default_nettype none

module rdc_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output rdc_pkg::rdc_cfg_t      cfg
);

  logic                            wr_en;
  logic [rdc_pkg::COORD_WIDTH-1:0] origin_x;
  logic [rdc_pkg::COORD_WIDTH-1:0] origin_y;
  logic [1:0]                      coord_source;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes in the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= rdc_pkg::ORIGIN_X_RESET;
      origin_y     <= rdc_pkg::ORIGIN_Y_RESET;
      coord_source <= rdc_pkg::SRC_RED;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        rdc_pkg::REG_ORIGIN_X:     origin_x     <= pwdata[rdc_pkg::COORD_WIDTH-1:0];
        rdc_pkg::REG_ORIGIN_Y:     origin_y     <= pwdata[rdc_pkg::COORD_WIDTH-1:0];
        rdc_pkg::REG_COORD_SOURCE: coord_source <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (paddr[3:2])
      rdc_pkg::REG_ORIGIN_X:     prdata = 32'(origin_x);
      rdc_pkg::REG_ORIGIN_Y:     prdata = 32'(origin_y);
      rdc_pkg::REG_COORD_SOURCE: prdata = 32'(coord_source);
      default:                   prdata = 32'd0;
    endcase
  end

  assign cfg.origin_x     = origin_x;
  assign cfg.origin_y     = origin_y;
  assign cfg.coord_source = coord_source;

endmodule

`default_nettype wire

@@ sv/rdc_geom.sv @@
// Input register and geometry stage: picks the coordinate pair, subtracts the center
// and looks up the heading sine and cosine. Depends on rdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdc_geom (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rdc_pkg::rdc_cfg_t cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rdc_pkg::rdc_raw_t in_raw,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rdc_pkg::rdc_vec_t      out_vec
);

  logic                            a_valid;
  rdc_pkg::rdc_raw_t               a_raw;
  logic                            b_valid;
  rdc_pkg::rdc_vec_t               b_vec;
  rdc_pkg::rdc_vec_t               b_vec_next;
  logic                            b_ready;
  logic [rdc_pkg::COORD_WIDTH-1:0] px;
  logic [rdc_pkg::COORD_WIDTH-1:0] py;
  logic [rdc_pkg::DEG_WIDTH-1:0]   h;
  logic [rdc_pkg::DEG_WIDTH-1:0]   h90;
  logic [rdc_pkg::DEG_WIDTH-1:0]   hc;

  assign b_ready  = !b_valid || out_ready;
  assign in_ready = !a_valid || b_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      a_raw <= in_raw;
    end
  end

  // Coordinate pair selection; the unused code falls to the camera pair
  always_comb begin
    case (cfg.coord_source)
      rdc_pkg::SRC_ROOM: begin
        px = a_raw.room_x;
        py = a_raw.room_y;
      end
      rdc_pkg::SRC_ARENA: begin
        px = a_raw.arena_x;
        py = a_raw.arena_y;
      end
      default: begin
        px = a_raw.red_x;
        py = a_raw.red_y;
      end
    endcase
  end

  // Heading reduced into 0..359, and the cosine angle a quarter turn on
  always_comb begin
    h   = (a_raw.heading >= rdc_pkg::DEG_360) ? a_raw.heading - rdc_pkg::DEG_360
                                              : a_raw.heading;
    h90 = h + rdc_pkg::DEG_90;
    hc  = (h90 >= rdc_pkg::DEG_360) ? h90 - rdc_pkg::DEG_360 : h90;
  end

  // Position vector relative to the center, sine and cosine
  always_comb begin
    b_vec_next.x    = $signed({1'b0, px}) - $signed({1'b0, cfg.origin_x});
    b_vec_next.y    = $signed({1'b0, py}) - $signed({1'b0, cfg.origin_y});
    b_vec_next.s    = rdc_pkg::sine_q15(h);
    b_vec_next.c    = rdc_pkg::sine_q15(hc);
    b_vec_next.live = a_raw.heading_valid && (px != cfg.origin_x || py != cfg.origin_y);
    b_vec_next.last = a_raw.final_record;
  end

  // Geometry register
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (a_valid && b_ready) begin
      b_vec <= b_vec_next;
    end
  end

  assign out_valid = b_valid;
  assign out_vec   = b_vec;

endmodule

`default_nettype wire

@@ sv/rdc_mult.sv @@
// Product stage: the four signed products that make up the cross and dot products.
// Depends on rdc_pkg for the stage types.
`timescale 1ns / 1ps
`default_nettype none

module rdc_mult (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rdc_pkg::rdc_vec_t in_vec,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rdc_pkg::rdc_prod_t     out_prod
);

  logic                                  c_valid;
  rdc_pkg::rdc_prod_t                    prod;
  rdc_pkg::rdc_prod_t                    prod_next;
  logic signed [rdc_pkg::VEC_WIDTH-1:0]  x;
  logic signed [rdc_pkg::VEC_WIDTH-1:0]  y;
  logic signed [rdc_pkg::SINE_WIDTH-1:0] s;
  logic signed [rdc_pkg::SINE_WIDTH-1:0] c;
  logic signed [rdc_pkg::PROD_WIDTH-1:0] sx;
  logic signed [rdc_pkg::PROD_WIDTH-1:0] cy;
  logic signed [rdc_pkg::PROD_WIDTH-1:0] cx;
  logic signed [rdc_pkg::PROD_WIDTH-1:0] sy;

  assign in_ready = !c_valid || out_ready;

  // Four independent multiplies at full product width
  always_comb begin
    x  = in_vec.x;
    y  = in_vec.y;
    s  = in_vec.s;
    c  = in_vec.c;
    sx = s * x;
    cy = c * y;
    cx = c * x;
    sy = s * y;
    prod_next.sx   = sx;
    prod_next.cy   = cy;
    prod_next.cx   = cx;
    prod_next.sy   = sy;
    prod_next.live = in_vec.live;
    prod_next.last = in_vec.last;
  end

  // Product register
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (in_ready) begin
      c_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      prod <= prod_next;
    end
  end

  assign out_valid = c_valid;
  assign out_prod  = prod;

endmodule

`default_nettype wire

@@ sv/rdc_decide.sv @@
// Decision stage: signs of the cross and dot products, the two saturating category
// counters and the result register. Depends on rdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdc_decide (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rdc_pkg::rdc_prod_t in_prod,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rdc_pkg::rdc_res_t       out_res
);

  logic                                 d_valid;
  rdc_pkg::rdc_res_t                    res;
  rdc_pkg::rdc_res_t                    res_next;
  logic [rdc_pkg::COUNT_WIDTH-1:0]      ccw_count;
  logic [rdc_pkg::COUNT_WIDTH-1:0]      cw_count;
  logic [rdc_pkg::COUNT_WIDTH-1:0]      ccw_after;
  logic [rdc_pkg::COUNT_WIDTH-1:0]      cw_after;
  logic [rdc_pkg::COUNT_WIDTH-1:0]      slot;
  logic signed [rdc_pkg::SUM_WIDTH-1:0] cross_sum;
  logic signed [rdc_pkg::SUM_WIDTH-1:0] dot;
  logic                                 is_ccw;
  logic                                 take;

  assign in_ready = !d_valid || out_ready;
  assign take     = in_valid && in_ready;

  // Rotation sense: cross product sign, dot product breaks a tie
  always_comb begin
    cross_sum = in_prod.sx - in_prod.cy;
    dot       = in_prod.cx + in_prod.sy;
    is_ccw    = (cross_sum > 0) || (cross_sum == 0 && dot > 0);
  end

  // Slot and saturating counts after this item
  always_comb begin
    ccw_after = ccw_count;
    cw_after  = cw_count;
    slot      = '0;
    if (in_prod.live) begin
      if (is_ccw) begin
        slot = ccw_count;
        if (ccw_count != rdc_pkg::COUNT_MAX) begin
          ccw_after = ccw_count + 1'b1;
        end
      end else begin
        slot = cw_count;
        if (cw_count != rdc_pkg::COUNT_MAX) begin
          cw_after = cw_count + 1'b1;
        end
      end
    end
    res_next.category  = !in_prod.live ? rdc_pkg::CAT_SKIP :
                         (is_ccw ? rdc_pkg::CAT_CCW : rdc_pkg::CAT_CW);
    res_next.slot      = rdc_pkg::OUT_WIDTH'(slot);
    res_next.ccw_total = rdc_pkg::OUT_WIDTH'(ccw_after);
    res_next.cw_total  = rdc_pkg::OUT_WIDTH'(cw_after);
    res_next.last      = in_prod.last;
  end

  // Counters clear after the last item of a session
  always_ff @(posedge clk) begin
    if (rst) begin
      ccw_count <= '0;
      cw_count  <= '0;
    end else if (take) begin
      ccw_count <= in_prod.last ? '0 : ccw_after;
      cw_count  <= in_prod.last ? '0 : cw_after;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (in_ready) begin
      d_valid <= in_valid;
    end
    if (take) begin
      res <= res_next;
    end
  end

  assign out_valid = d_valid;
  assign out_res   = res;

endmodule

`default_nettype wire

@@ dv/tb_rotation_direction_classifier.sv @@
// Self-checking testbench for the rotation direction classifier: stream records in,
// predict each result in the testbench and compare it field by field as it leaves.
// Depends on rdc_pkg and rotation_direction_classifier.
`timescale 1ns / 1ps

module tb_rotation_direction_classifier;

  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE      = 8;
  localparam int COORD_W     = rdc_pkg::COORD_WIDTH;
  localparam int DEG_W       = rdc_pkg::DEG_WIDTH;
  localparam int COUNT_W     = rdc_pkg::COUNT_WIDTH;
  // Source code with no pair of its own; the block reads the camera pair for it.
  localparam logic [1:0] SRC_SPARE = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // room_x, room_y, arena_x, arena_y, red_x, red_y (10 bits each), heading (9), pad
  logic [71:0] s_axis_tdata;
  // heading_valid
  logic [0:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // category (2), slot (24), ccw_total (24), cw_total (24), pad
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rotation_direction_classifier u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Shadow copy of the registers and the session counters.
  logic [COORD_W-1:0] cfg_origin_x;
  logic [COORD_W-1:0] cfg_origin_y;
  logic [1:0]         cfg_source;
  logic [COUNT_W-1:0] ccw_seen;
  logic [COUNT_W-1:0] cw_seen;

  rdc_pkg::rdc_res_t expected_results[$];

  int  errors;
  int  records_sent;
  int  results_checked;
  int  skip_results;
  int  ccw_results;
  int  cw_results;
  int  settings_applied;
  int  stall_cycles;
  int  hold_request;
  bit  quiet;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Signed Q1.15 sine of a heading in 0..359 degrees.
  function automatic longint sine_of(int unsigned deg);
    if (deg <= 90)
      return longint'(rdc_pkg::SINE_ROM[deg]);
    else if (deg <= 180)
      return longint'(rdc_pkg::SINE_ROM[180 - deg]);
    else if (deg <= 270)
      return -longint'(rdc_pkg::SINE_ROM[deg - 180]);
    return -longint'(rdc_pkg::SINE_ROM[360 - deg]);
  endfunction

  // Works out the result of one accepted record and advances the counters.
  function automatic rdc_pkg::rdc_res_t classify_record(rdc_pkg::rdc_raw_t rec);
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    int                 x;
    int                 y;
    int unsigned        h;
    longint             s;
    longint             c;
    longint             cross_sum;
    longint             dot;
    rdc_pkg::rdc_res_t  r;
    case (cfg_source)
      rdc_pkg::SRC_ROOM: begin
        px = rec.room_x;
        py = rec.room_y;
      end
      rdc_pkg::SRC_ARENA: begin
        px = rec.arena_x;
        py = rec.arena_y;
      end
      default: begin
        px = rec.red_x;
        py = rec.red_y;
      end
    endcase
    x = int'(px) - int'(cfg_origin_x);
    y = int'(py) - int'(cfg_origin_y);
    h = 32'(rec.heading);
    if (h >= 360)
      h -= 360;
    r = '0;
    r.last = rec.final_record;
    if (rec.heading_valid && !(x == 0 && y == 0)) begin
      s = sine_of(h);
      c = sine_of((h + 90) % 360);
      cross_sum = s * x - c * y;
      dot = c * x + s * y;
      if (cross_sum > 0 || (cross_sum == 0 && dot > 0)) begin
        r.category = rdc_pkg::CAT_CCW;
        r.slot = ccw_seen;
        if (ccw_seen < rdc_pkg::COUNT_MAX)
          ccw_seen++;
      end else begin
        r.category = rdc_pkg::CAT_CW;
        r.slot = cw_seen;
        if (cw_seen < rdc_pkg::COUNT_MAX)
          cw_seen++;
      end
    end
    r.ccw_total = ccw_seen;
    r.cw_total = cw_seen;
    if (rec.final_record) begin
      ccw_seen = '0;
      cw_seen = '0;
    end
    return r;
  endfunction

  // A record whose selected pair is (px, py); the other pairs carry noise.
  function automatic rdc_pkg::rdc_raw_t placed_record(logic [COORD_W-1:0] px,
                                                      logic [COORD_W-1:0] py,
                                                      logic [DEG_W-1:0] h, logic hv,
                                                      logic fin);
    rdc_pkg::rdc_raw_t r;
    r.room_x = COORD_W'($urandom_range(0, 1023));
    r.room_y = COORD_W'($urandom_range(0, 1023));
    r.arena_x = COORD_W'($urandom_range(0, 1023));
    r.arena_y = COORD_W'($urandom_range(0, 1023));
    r.red_x = COORD_W'($urandom_range(0, 1023));
    r.red_y = COORD_W'($urandom_range(0, 1023));
    r.heading = h;
    r.heading_valid = hv;
    r.final_record = fin;
    case (cfg_source)
      rdc_pkg::SRC_ROOM: begin
        r.room_x = px;
        r.room_y = py;
      end
      rdc_pkg::SRC_ARENA: begin
        r.arena_x = px;
        r.arena_y = py;
      end
      default: begin
        r.red_x = px;
        r.red_y = py;
      end
    endcase
    return r;
  endfunction

  // Random record, biased towards the centre, the axes, diagonals and tie headings.
  function automatic rdc_pkg::rdc_raw_t random_record();
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] d;
    logic [DEG_W-1:0]   h;
    int                 pick;
    px = COORD_W'($urandom_range(0, 1023));
    py = COORD_W'($urandom_range(0, 1023));
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        px = cfg_origin_x;
        py = cfg_origin_y;
      end
      1: py = cfg_origin_y;
      2: px = cfg_origin_x;
      3: begin
        d = COORD_W'($urandom_range(0, 1023));
        px = cfg_origin_x + d;
        py = cfg_origin_y + d;
      end
      4: begin
        px = cfg_origin_x + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
        py = cfg_origin_y + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
      end
      default: ;
    endcase
    pick = $urandom_range(0, 15);
    if (pick < 3)
      h = DEG_W'(45 * $urandom_range(0, 7));
    else if (pick < 5)
      h = DEG_W'($urandom_range(360, 511));
    else
      h = DEG_W'($urandom_range(0, 359));
    return placed_record(px, py, h, $urandom_range(0, 9) != 0, 1'b0);
  endfunction

  function automatic logic [31:0] reg_shadow(logic [1:0] idx);
    case (idx)
      rdc_pkg::REG_ORIGIN_X: return 32'(cfg_origin_x);
      rdc_pkg::REG_ORIGIN_Y: return 32'(cfg_origin_y);
      default:               return 32'(cfg_source);
    endcase
  endfunction

  // APB write: setup cycle, then access cycle; the shadow follows the write edge.
  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = 4'({idx, 2'b00});
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      rdc_pkg::REG_ORIGIN_X: cfg_origin_x = value[COORD_W-1:0];
      rdc_pkg::REG_ORIGIN_Y: cfg_origin_y = value[COORD_W-1:0];
      default:               cfg_source = value[1:0];
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // APB read, compared with the shadow copy.
  task automatic check_reg(logic [1:0] idx);
    logic [31:0] got;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 4'({idx, 2'b00});
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== reg_shadow(idx)) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: register %0d read %0h, expected %0h", idx, got, reg_shadow(idx));
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Writes all three registers, with noise in the unused upper bits, and reads them back.
  task automatic apply_setting(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                               logic [1:0] src);
    reg_write(rdc_pkg::REG_ORIGIN_X, ($urandom & ~32'h3FF) | 32'(cx));
    reg_write(rdc_pkg::REG_ORIGIN_Y, ($urandom & ~32'h3FF) | 32'(cy));
    reg_write(rdc_pkg::REG_COORD_SOURCE, ($urandom & ~32'h3) | 32'(src));
    check_reg(rdc_pkg::REG_ORIGIN_X);
    check_reg(rdc_pkg::REG_ORIGIN_Y);
    check_reg(rdc_pkg::REG_COORD_SOURCE);
    settings_applied++;
  endtask

  // Offers one record and holds it until the block takes it.
  task automatic send_record(rdc_pkg::rdc_raw_t rec);
    @(negedge clk);
    s_axis_tdata = {3'b000, rec.heading, rec.red_y, rec.red_x, rec.arena_y, rec.arena_x,
                    rec.room_y, rec.room_x};
    s_axis_tuser = rec.heading_valid;
    s_axis_tlast = rec.final_record;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    expected_results.push_back(classify_record(rec));
    records_sent++;
  endtask

  // Random sender gap, unless the run is in its quiet tail.
  task automatic maybe_pause();
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 19);
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random records in sessions of random length; optionally the last one ends a session.
  task automatic stream_records(int count, bit gaps, bit close_session);
    rdc_pkg::rdc_raw_t rec;
    for (int i = 0; i < count; i++) begin
      rec = random_record();
      rec.final_record = ($urandom_range(0, 19) == 0) || (close_session && i == count - 1);
      send_record(rec);
      if (gaps)
        maybe_pause();
    end
  endtask

  // Reset values of the registers, then a few records with them.
  task automatic test_reset_defaults();
    check_reg(rdc_pkg::REG_ORIGIN_X);
    check_reg(rdc_pkg::REG_ORIGIN_Y);
    check_reg(rdc_pkg::REG_COORD_SOURCE);
    stream_records(6, 1'b1, 1'b0);
    wait_idle();
  endtask

  // Skips, ties on the axes and diagonals, headings past 359, extremes and session end.
  task automatic test_special_cases();
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    cx = cfg_origin_x;
    cy = cfg_origin_y;
    send_record(placed_record(cx + 10'd40, cy + 10'd7, 9'd30, 1'b0, 1'b0));
    send_record(placed_record(cx, cy, 9'd100, 1'b1, 1'b0));
    send_record(placed_record(cx + 10'd88, cy, 9'd0, 1'b1, 1'b0));
    send_record(placed_record(cx - 10'd88, cy, 9'd0, 1'b1, 1'b0));
    send_record(placed_record(cx, cy + 10'd188, 9'd90, 1'b1, 1'b0));
    send_record(placed_record(cx, cy - 10'd188, 9'd90, 1'b1, 1'b0));
    send_record(placed_record(cx + 10'd188, cy, 9'd180, 1'b1, 1'b0));
    send_record(placed_record(cx, cy + 10'd5, 9'd270, 1'b1, 1'b0));
    send_record(placed_record(cx + 10'd88, cy + 10'd88, 9'd45, 1'b1, 1'b0));
    send_record(placed_record(cx + 10'd88, cy + 10'd88, 9'd225, 1'b1, 1'b0));
    send_record(placed_record(cx + 10'd3, cy - 10'd9, 9'd359, 1'b1, 1'b0));
    send_record(placed_record(cx + 10'd88, cy, 9'd360, 1'b1, 1'b0));
    send_record(placed_record(cx - 10'd20, cy + 10'd61, 9'd511, 1'b1, 1'b0));
    send_record(placed_record(cx, cy + 10'd188, 9'd450, 1'b1, 1'b0));
    send_record(placed_record(10'd0, 10'd0, 9'd135, 1'b1, 1'b0));
    send_record(placed_record(10'd1023, 10'd1023, 9'd315, 1'b1, 1'b0));
    send_record(placed_record(10'd0, 10'd1023, 9'd0, 1'b1, 1'b0));
    send_record(placed_record(10'd1023, 10'd0, 9'd200, 1'b1, 1'b1));
    send_record(placed_record(cx + 10'd1, cy, 9'd0, 1'b1, 1'b0));
    wait_idle();
    // The unused source code reads the camera pair.
    apply_setting(cfg_origin_x, cfg_origin_y, SRC_SPARE);
    send_record(placed_record(cx + 10'd50, cy - 10'd60, 9'd10, 1'b1, 1'b0));
    send_record(placed_record(cx, cy, 9'd10, 1'b1, 1'b0));
    wait_idle();
    apply_setting(cfg_origin_x, cfg_origin_y, rdc_pkg::SRC_ROOM);
    send_record(placed_record(cx - 10'd50, cy + 10'd60, 9'd300, 1'b1, 1'b0));
    wait_idle();
    apply_setting(cfg_origin_x, cfg_origin_y, rdc_pkg::SRC_ARENA);
    send_record(placed_record(cx + 10'd70, cy + 10'd60, 9'd120, 1'b1, 1'b1));
    wait_idle();
  endtask

  // Extreme centres with every source code.
  task automatic test_setting_sweep();
    apply_setting(10'd0, 10'd0, rdc_pkg::SRC_ROOM);
    stream_records(30, 1'b1, 1'b1);
    wait_idle();
    apply_setting(10'd1023, 10'd1023, rdc_pkg::SRC_ARENA);
    stream_records(30, 1'b1, 1'b0);
    wait_idle();
    apply_setting(10'd0, 10'd1023, rdc_pkg::SRC_RED);
    stream_records(30, 1'b1, 1'b1);
    wait_idle();
    apply_setting(10'd1023, 10'd0, SRC_SPARE);
    stream_records(30, 1'b1, 1'b0);
    wait_idle();
  endtask

  // Long receiver hold-off while the sender keeps offering, so the pipeline fills.
  task automatic test_output_stall();
    apply_setting(COORD_W'($urandom_range(0, 1023)), COORD_W'($urandom_range(0, 1023)),
                  rdc_pkg::SRC_RED);
    hold_request = 90;
    stream_records(30, 1'b0, 1'b0);
    wait_idle();
  endtask

  // Sessions separated by full drains of the pipeline.
  task automatic test_drained_sessions();
    for (int i = 0; i < 3; i++) begin
      stream_records(14, 1'b1, 1'b1);
      wait_idle();
    end
  endtask

  // Bulk random sessions under several random settings.
  task automatic test_random_sessions();
    for (int i = 0; i < 4; i++) begin
      apply_setting(COORD_W'($urandom_range(0, 1023)), COORD_W'($urandom_range(0, 1023)),
                    2'($urandom_range(0, 3)));
      stream_records(50, 1'b1, 1'b0);
      wait_idle();
    end
  endtask

  // Back-to-back traffic with the receiver always ready.
  task automatic test_quiet_tail();
    quiet = 1'b1;
    stream_records(45, 1'b0, 1'b1);
    wait_idle();
  endtask

  // Receiver: random stall bursts, an occasional long hold-off, none in the quiet tail.
  initial begin : receiver
    int n;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        m_axis_tready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 19);
        m_axis_tready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Each accepted result against the oldest expectation.
  always @(posedge clk) begin : result_checker
    rdc_pkg::rdc_res_t got;
    rdc_pkg::rdc_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.category = m_axis_tdata[1:0];
      got.slot = m_axis_tdata[25:2];
      got.ccw_total = m_axis_tdata[49:26];
      got.cw_total = m_axis_tdata[73:50];
      got.last = m_axis_tlast;
      results_checked++;
      case (got.category)
        rdc_pkg::CAT_SKIP: skip_results++;
        rdc_pkg::CAT_CCW:  ccw_results++;
        default:           cw_results++;
      endcase
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result cat=%0d slot=%0d ccw=%0d cw=%0d last=%0b",
                   got.category, got.slot, got.ccw_total, got.cw_total, got.last);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("ERROR: result %0d expected cat=%0d slot=%0d ccw=%0d cw=%0d last=%0b",
                     results_checked, want.category, want.slot, want.ccw_total,
                     want.cw_total, want.last);
            $display("       got cat=%0d slot=%0d ccw=%0d cw=%0d last=%0b",
                     got.category, got.slot, got.ccw_total, got.cw_total, got.last);
          end
        end
      end
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_origin_x = rdc_pkg::ORIGIN_X_RESET;
    cfg_origin_y = rdc_pkg::ORIGIN_Y_RESET;
    cfg_source = rdc_pkg::SRC_RED;
    ccw_seen = '0;
    cw_seen = '0;
    errors = 0;
    records_sent = 0;
    results_checked = 0;
    skip_results = 0;
    ccw_results = 0;
    cw_results = 0;
    settings_applied = 0;
    stall_cycles = 0;
    hold_request = 0;
    quiet = 1'b0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_special_cases();
    test_setting_sweep();
    test_output_stall();
    test_drained_sessions();
    test_random_sessions();
    test_quiet_tail();

    if (expected_results.size() != 0) begin
      errors += expected_results.size();
      $display("ERROR: %0d results never arrived", expected_results.size());
    end
    $display("Run covered %0d records and %0d results (%0d skipped, %0d ccw, %0d cw)",
             records_sent, results_checked, skip_results, ccw_results, cw_results);
    $display("over %0d register settings, all source codes, centre extremes and a long stall",
             settings_applied);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ rotation_direction_classifier.f @@
sv/rdc_pkg.sv
sv/rdc_cfg.sv
sv/rdc_geom.sv
sv/rdc_mult.sv
sv/rdc_decide.sv
sv/rotation_direction_classifier.sv
dv/tb_rotation_direction_classifier.sv
